// ===== rtl/core/spwm_pkg.sv =====
// Shared types, codes and constants of the sixteen-channel PWM controller.
`timescale 1ns / 1ps

package spwm_pkg;

  // Upper bounds of the top-level parameters; item fields are sized for them.
  localparam int MAX_CHANNELS     = 16;
  localparam int MAX_COUNTER_BITS = 16;
  localparam int CH_IDX_W         = 4;

  // Default register map and sizes.
  localparam int DEF_CHANNELS          = 16;
  localparam int DEF_COUNTER_BITS      = 12;
  localparam int DEF_MODE_ADDR         = 0;
  localparam int DEF_CHANNEL_BASE_ADDR = 6;
  localparam int DEF_ALL_BASE_ADDR     = 250;
  localparam int DEF_PRESCALE_ADDR     = 254;

  // Mode register bits and channel high-byte bits.
  localparam int BIT_RESTART = 7;
  localparam int BIT_AUTOINC = 5;
  localparam int BIT_SLEEP   = 4;
  localparam int BIT_FULL    = 4;

  localparam logic [7:0] MODE_RESET     = 8'h11;
  localparam logic [7:0] PRESCALE_RESET = 8'd30;
  localparam logic [7:0] PRESCALE_MIN   = 8'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } spwm_op_t;

  // Byte position inside one channel's four registers.
  typedef enum logic [1:0] {
    K_ON_L  = 2'd0,
    K_ON_H  = 2'd1,
    K_OFF_L = 2'd2,
    K_OFF_H = 2'd3
  } spwm_byte_t;

  // One transaction as it travels down the chain of channel cells.
  typedef struct packed {
    logic                        valid;
    logic                        wr;      // write to channel bytes
    logic                        bcast;   // write goes to every channel
    logic                        rd;      // read of a channel byte
    logic [CH_IDX_W-1:0]         ch;
    spwm_byte_t                  k;
    logic [7:0]                  data;
    logic                        upd;     // counter stepped, re-evaluate levels
    logic [MAX_COUNTER_BITS-1:0] count;
    logic                        asleep;
    logic [7:0]                  rdata;
    logic [MAX_CHANNELS-1:0]     levels;
  } spwm_item_t;

endpackage

// ===== rtl/core/spwm_front.sv =====
// Global control of the PWM controller: mode, prescale, divider, counter and pointer.
`timescale 1ns / 1ps

module spwm_front import spwm_pkg::*; #(
  parameter int CHANNELS          = DEF_CHANNELS,
  parameter int COUNTER_BITS      = DEF_COUNTER_BITS,
  parameter int MODE_ADDR         = DEF_MODE_ADDR,
  parameter int CHANNEL_BASE_ADDR = DEF_CHANNEL_BASE_ADDR,
  parameter int ALL_BASE_ADDR     = DEF_ALL_BASE_ADDR,
  parameter int PRESCALE_ADDR     = DEF_PRESCALE_ADDR
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       take,
  input  spwm_op_t   opcode,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       burst_next,
  output spwm_item_t item
);

  localparam logic [7:0] LAST_CH_ADDR = 8'((CHANNEL_BASE_ADDR + 4 * CHANNELS - 1) % 256);
  localparam logic [9:0] CH_END       = 10'(CHANNEL_BASE_ADDR + 4 * CHANNELS);
  localparam logic [9:0] ALL_END      = 10'(ALL_BASE_ADDR + 4);

  logic [7:0]              mode, mode_next;
  logic [7:0]              prescale, prescale_next;
  logic [7:0]              divider, divider_next;
  logic [COUNTER_BITS-1:0] count, count_next;
  logic [7:0]              pointer, pointer_next;
  spwm_item_t              item_next;

  logic [7:0] addr;
  logic [9:0] a10;
  logic [7:0] off;
  logic       is_mode, is_pre, is_all, is_ch, access;

  always_comb begin
    mode_next     = mode;
    prescale_next = prescale;
    divider_next  = divider;
    count_next    = count;
    pointer_next  = pointer;
    access        = (opcode == OP_WRITE) || (opcode == OP_READ);

    addr = reg_addr;
    if (burst_next && mode[BIT_AUTOINC]) begin
      addr = (pointer == LAST_CH_ADDR) ? 8'd0 : pointer + 8'd1;
    end
    a10     = {2'b00, addr};
    is_mode = (addr == 8'(MODE_ADDR));
    is_pre  = !is_mode && (addr == 8'(PRESCALE_ADDR));
    is_all  = !is_mode && !is_pre && (a10 >= 10'(ALL_BASE_ADDR)) && (a10 < ALL_END);
    is_ch   = !is_mode && !is_pre && !is_all &&
              (a10 >= 10'(CHANNEL_BASE_ADDR)) && (a10 < CH_END);
    off     = addr - 8'(CHANNEL_BASE_ADDR);

    item_next        = '0;
    item_next.valid  = 1'b1;
    item_next.data   = write_data;
    item_next.ch     = off[2 +: CH_IDX_W];
    item_next.k      = is_all ? spwm_byte_t'(addr - 8'(ALL_BASE_ADDR))
                              : spwm_byte_t'(off[1:0]);

    if (access) begin
      pointer_next = addr;
    end

    case (opcode)
      OP_WRITE: begin
        if (is_mode) begin
          mode_next = {mode[BIT_RESTART], write_data[6:0]};
          if (!mode[BIT_SLEEP] && mode_next[BIT_SLEEP]) begin
            mode_next[BIT_RESTART] = 1'b1;
          end
          if (write_data[BIT_RESTART] && mode[BIT_RESTART] && !mode_next[BIT_SLEEP]) begin
            mode_next[BIT_RESTART] = 1'b0;
            divider_next           = '0;
            count_next             = '0;
          end
        end else if (is_pre) begin
          if (mode[BIT_SLEEP]) begin
            prescale_next = (write_data < PRESCALE_MIN) ? PRESCALE_MIN : write_data;
          end
        end else begin
          item_next.wr    = is_all || is_ch;
          item_next.bcast = is_all;
        end
      end
      OP_READ: begin
        if (is_mode) begin
          item_next.rdata = mode;
        end else if (is_pre) begin
          item_next.rdata = prescale;
        end else begin
          item_next.rd = is_ch;
        end
      end
      OP_TICK: begin
        if (!mode[BIT_SLEEP]) begin
          if (divider >= prescale) begin
            divider_next  = '0;
            count_next    = count + 1'b1;
            item_next.upd = 1'b1;
          end else begin
            divider_next = divider + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase

    item_next.count  = MAX_COUNTER_BITS'(count_next);
    item_next.asleep = mode_next[BIT_SLEEP];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_RESET;
      prescale   <= PRESCALE_RESET;
      divider    <= '0;
      count      <= '0;
      pointer    <= '0;
      item       <= '0;
    end else if (adv) begin
      if (take) begin
        mode     <= mode_next;
        prescale <= prescale_next;
        divider  <= divider_next;
        count    <= count_next;
        pointer  <= pointer_next;
        item     <= item_next;
      end else begin
        item.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/spwm_cell.sv =====
// One channel cell: four channel registers, the output level and one chain stage.
`timescale 1ns / 1ps

module spwm_cell import spwm_pkg::*; #(
  parameter int IDX          = 0,
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  spwm_item_t item_in,
  output spwm_item_t item_out
);

  logic [7:0] on_l, off_l;
  logic [4:0] on_h, off_h;
  logic       level, level_next;
  logic       hit;
  logic [15:0] on16, off16;
  logic [7:0]  rbyte;
  spwm_item_t  item_next;

  always_comb begin
    hit   = (item_in.ch == CH_IDX_W'(IDX));
    on16  = {4'h0, on_h[3:0], on_l};
    off16 = {4'h0, off_h[3:0], off_l};

    level_next = level;
    if (item_in.upd) begin
      if (off_h[BIT_FULL]) begin
        level_next = 1'b0;
      end else if (on_h[BIT_FULL]) begin
        level_next = 1'b1;
      end else begin
        if (item_in.count[COUNTER_BITS-1:0] == on16[COUNTER_BITS-1:0]) begin
          level_next = 1'b1;
        end
        if (item_in.count[COUNTER_BITS-1:0] == off16[COUNTER_BITS-1:0]) begin
          level_next = 1'b0;
        end
      end
    end

    case (item_in.k)
      K_ON_L:  rbyte = on_l;
      K_ON_H:  rbyte = {3'b000, on_h};
      K_OFF_L: rbyte = off_l;
      K_OFF_H: rbyte = {3'b000, off_h};
      default: rbyte = 8'h00;
    endcase

    item_next = item_in;
    if (item_in.rd && hit) begin
      item_next.rdata = rbyte;
    end
    item_next.levels[IDX] = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_l     <= '0;
      on_h     <= '0;
      off_l    <= '0;
      off_h    <= 5'h10;
      level    <= 1'b0;
      item_out <= '0;
    end else if (adv) begin
      item_out <= item_next;
      if (item_in.valid) begin
        level <= level_next;
        if (item_in.wr && (item_in.bcast || hit)) begin
          case (item_in.k)
            K_ON_L:  on_l  <= item_in.data;
            K_ON_H:  on_h  <= item_in.data[4:0];
            K_OFF_L: off_l <= item_in.data;
            K_OFF_H: off_h <= item_in.data[4:0];
            default: begin
            end
          endcase
        end
      end
    end
  end

endmodule

// ===== rtl/core/sixteen_channel_pwm_controller.sv =====
// Top level of the sixteen-channel PWM controller: control stage, cell chain and output skid.
`timescale 1ns / 1ps

// Each input transaction is a register write, a register read or one oscillator tick, and
// each produces exactly one result transaction carrying the byte read (zero for anything but
// a read) and the level of every channel after the step (zero while the sleep bit is set).
// A new transaction is accepted every clock cycle while the skid buffer is empty. Each
// transaction travels a chain to the output: a control stage, registered at the accepting
// edge itself, resolves the address, mode, prescale, divider and counter, then the
// transaction passes through one cell per channel, each cell applying writes, serving
// reads and stepping its own level against the shared counter, and finally an output
// register with a one-entry skid buffer, so the input keeps being taken while one finished
// result waits to be collected. Once the skid buffer is occupied, the chain and the input
// stall until the output register is freed.
// The register map follows the usual device layout: the mode byte, four bytes per channel
// (12-bit on and off counts with full-on and full-off bits), a broadcast group that writes
// every channel and reads as zero, and a prescale byte that can only be written while asleep.

module sixteen_channel_pwm_controller import spwm_pkg::*; #(
  parameter int CHANNELS          = DEF_CHANNELS,
  parameter int COUNTER_BITS      = DEF_COUNTER_BITS,
  parameter int MODE_ADDR         = DEF_MODE_ADDR,
  parameter int CHANNEL_BASE_ADDR = DEF_CHANNEL_BASE_ADDR,
  parameter int ALL_BASE_ADDR     = DEF_ALL_BASE_ADDR,
  parameter int PRESCALE_ADDR     = DEF_PRESCALE_ADDR
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // reg_addr [7:0], write_data [15:8]
  input  logic [2:0]  s_tuser,   // opcode [1:0], burst_next [2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_data [7:0], pwm_out [23:8]
);

  spwm_item_t stage [CHANNELS+1];

  logic        adv;
  logic        take;
  logic [23:0] chain_data;
  logic [23:0] skid_data;
  logic        skid_valid;
  logic [MAX_CHANNELS-1:0] lv;

  // The chain moves whenever the skid buffer is empty; the skid then absorbs the one
  // result that may leave the chain while the output register is held.
  assign adv      = !skid_valid;
  assign s_tready = adv;
  assign take     = s_tvalid && adv;

  spwm_front #(
    .CHANNELS          (CHANNELS),
    .COUNTER_BITS      (COUNTER_BITS),
    .MODE_ADDR         (MODE_ADDR),
    .CHANNEL_BASE_ADDR (CHANNEL_BASE_ADDR),
    .ALL_BASE_ADDR     (ALL_BASE_ADDR),
    .PRESCALE_ADDR     (PRESCALE_ADDR)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .take       (take),
    .opcode     (spwm_op_t'(s_tuser[1:0])),
    .reg_addr   (s_tdata[7:0]),
    .write_data (s_tdata[15:8]),
    .burst_next (s_tuser[2]),
    .item       (stage[0])
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    spwm_cell #(
      .IDX          (i),
      .COUNTER_BITS (COUNTER_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .item_in  (stage[i]),
      .item_out (stage[i+1])
    );
  end

  // Only the levels of implemented channels are reported; all are forced low while asleep.
  always_comb begin
    lv = '0;
    if (!stage[CHANNELS].asleep) begin
      lv[CHANNELS-1:0] = stage[CHANNELS].levels[CHANNELS-1:0];
    end
    chain_data = {lv, stage[CHANNELS].rdata};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata    <= skid_data;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else if (stage[CHANNELS].valid) begin
        m_tdata  <= chain_data;
        m_tvalid <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (adv && stage[CHANNELS].valid) begin
      skid_data  <= chain_data;
      skid_valid <= 1'b1;
    end
  end

  // A result held in the skid buffer always has an older one in front of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid buffer holds a result while the output register is empty");

  // An accepted transaction enters the chain in the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    take |=> stage[0].valid)
    else $error("accepted transaction did not enter the chain");

  // The skid buffer only fills when the output is held back.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid buffer filled although the output register was free");

endmodule
